>>> hdl/mfdlm_pkg.sv
package mfdlm_pkg;

    localparam int DEDUP_DEPTH_DEF = 16;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int KEY_W       = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PREF    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SIGNAL_MS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS        = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS        = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT_LEN  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TYPE      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FRAME_LEN = 4'd7;

    // item kinds
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // channels and bar thresholds
    localparam logic [3:0]  CHAN_SCAN_A = 4'd11;
    localparam logic [3:0]  CHAN_SCAN_B = 4'd1;
    localparam logic [3:0]  CHAN_MAX    = 4'd14;
    localparam logic [31:0] BAR4_MS     = 32'd500;
    localparam logic [31:0] BAR3_MS     = 32'd1000;
    localparam logic [31:0] BAR2_MS     = 32'd2000;

    localparam logic [2:0] BARS_0 = 3'd0;
    localparam logic [2:0] BARS_1 = 3'd1;
    localparam logic [2:0] BARS_2 = 3'd2;
    localparam logic [2:0] BARS_3 = 3'd3;
    localparam logic [2:0] BARS_4 = 3'd4;

    // register reset values
    localparam logic [15:0] NO_SIGNAL_RST = 16'd3000;
    localparam logic [15:0] DWELL_RST     = 16'd2000;
    localparam logic [7:0]  MAX_HOPS_RST  = 8'd3;
    localparam logic [7:0]  MAX_LEN_RST   = 8'd250;

    typedef struct packed {
        logic        lt;
        logic        eq;
        logic [31:0] diff;
    } alu_res_t;

    function automatic int idx_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> hdl/mfdlm_ram.sv
module mfdlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [mfdlm_pkg::idx_w(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [mfdlm_pkg::idx_w(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]                       rdata
);
    import mfdlm_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> hdl/mfdlm_alu.sv
module mfdlm_alu (
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output mfdlm_pkg::alu_res_t res
);
    import mfdlm_pkg::*;

    // subtract and compares work on the same operands; diff wraps
    always_comb
    begin
        res.diff = a - b;
        res.lt   = (a < b);
        res.eq   = (a == b);
    end

endmodule

>>> hdl/mesh_frame_dedup_link_monitor_core.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: frame fields, tuser: item kind
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: one result item per input item
// cfg       in   cfg_valid/cfg_ready            cfg_index, cfg_data
//
// Good-header frame with nonzero sequence: walks the ring, one RAM read and one compare a cycle,
// and a duplicate ends the walk early.
// Tick: eight steps on the shared subtract/compare unit.
// Input is not ready while an item is in work, nor while a finished item waits for
// the previous result to be taken.
// Reset clears all control and link state; the ring holds no stale matches after reset.
module mesh_frame_dedup_link_monitor_core #(
    parameter int DEDUP_DEPTH = mfdlm_pkg::DEDUP_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_ms, header_ok, src_node, sequence_req, hop_cnt, msg_code,
    // frame_len, payload_ok, zero fill
    input  logic [mfdlm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // duplicate, repeat_res, repeat_hop, deliver_light, signal_lost,
    // entered_no_signal, listen_channel, channel_switched, bar_level, zero fill
    output logic [mfdlm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfdlm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfdlm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfdlm_pkg::*;

    localparam int IW = idx_w(DEDUP_DEPTH);
    localparam int CW = $clog2(DEDUP_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [2:0] T_AGE    = 3'd0;
    localparam logic [2:0] T_GTNS   = 3'd1;
    localparam logic [2:0] T_LT500  = 3'd2;
    localparam logic [2:0] T_LT1000 = 3'd3;
    localparam logic [2:0] T_LT2000 = 3'd4;
    localparam logic [2:0] T_LTNS   = 3'd5;
    localparam logic [2:0] T_SWD    = 3'd6;
    localparam logic [2:0] T_DWELL  = 3'd7;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    tstep_reg, tstep_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          hit_reg, hit_next;
    logic [7:0]    flags_reg, flags_next;
    logic [31:0]   age_reg, age_next;
    logic [31:0]   swd_reg, swd_next;

    logic        act_reg;
    logic [31:0] now_reg;
    logic        hdr_reg;
    logic [7:0]  src_reg;
    logic [7:0]  seq_reg;
    logic [7:0]  hop_reg;
    logic [7:0]  mt_reg;
    logic [7:0]  flen_reg;
    logic        pay_reg;

    logic [3:0]  pref_reg, pref_next;
    logic        rep_en_reg, rep_en_next;
    logic [15:0] ns_reg, ns_next;
    logic [15:0] dwell_reg, dwell_next;
    logic [7:0]  maxhop_reg, maxhop_next;
    logic [7:0]  maxlen_reg, maxlen_next;
    logic [7:0]  ltype_reg, ltype_next;
    logic [7:0]  llen_reg, llen_next;

    logic          heard_reg, heard_next;
    logic [31:0]   last_rx_reg, last_rx_next;
    logic          lost_reg, lost_next;
    logic [3:0]    chan_reg, chan_next;
    logic [31:0]   last_sw_reg, last_sw_next;
    logic [IW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic          in_fire;
    logic          cfg_fire;
    logic          fin_fire;
    logic          ram_we;
    logic [KEY_W-1:0] ram_rdata;
    logic [KEY_W-1:0] key;
    logic [CW-1:0] prev_idx;
    logic [31:0]   alu_a, alu_b;
    alu_res_t      alu_res;

    logic        r_dup, r_rep, r_light, r_unique, r_enter, r_switch;
    logic [7:0]  r_hop;
    logic [2:0]  r_bars;
    logic [3:0]  r_chan;
    logic        r_lost;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign fin_fire      = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);
    assign key           = {src_reg, seq_reg};
    assign prev_idx      = scan_reg - CW'(1);

    mfdlm_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEDUP_DEPTH)
    ) u_ring (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wptr_reg),
        .wdata(key),
        .raddr(scan_reg[IW-1:0]),
        .rdata(ram_rdata)
    );

    mfdlm_alu u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .res(alu_res)
    );

    // shared unit operand selection
    always_comb
    begin
        alu_a = now_reg;
        alu_b = last_rx_reg;
        if (state_reg == ST_SCAN)
        begin
            alu_a = 32'(ram_rdata);
            alu_b = 32'(key);
        end
        else if (state_reg == ST_TICK)
        begin
            unique case (tstep_reg)
                T_AGE:
                begin
                    alu_a = now_reg;
                    alu_b = last_rx_reg;
                end
                T_GTNS:
                begin
                    alu_a = 32'(ns_reg);
                    alu_b = age_reg;
                end
                T_LT500:
                begin
                    alu_a = age_reg;
                    alu_b = BAR4_MS;
                end
                T_LT1000:
                begin
                    alu_a = age_reg;
                    alu_b = BAR3_MS;
                end
                T_LT2000:
                begin
                    alu_a = age_reg;
                    alu_b = BAR2_MS;
                end
                T_LTNS:
                begin
                    alu_a = age_reg;
                    alu_b = 32'(ns_reg);
                end
                T_SWD:
                begin
                    alu_a = now_reg;
                    alu_b = last_sw_reg;
                end
                T_DWELL:
                begin
                    alu_a = swd_reg;
                    alu_b = 32'(dwell_reg);
                end
            endcase
        end
    end

    // result of the item in work
    always_comb
    begin
        r_unique = hdr_reg && !hit_reg;
        r_dup    = hdr_reg && hit_reg;
        r_rep    = r_unique && rep_en_reg && (hop_reg < maxhop_reg)
                   && (flen_reg <= maxlen_reg);
        r_hop    = r_rep ? (hop_reg + 8'd1) : 8'd0;
        r_light  = r_unique && (mt_reg == ltype_reg) && (flen_reg == llen_reg) && pay_reg;
        r_enter  = heard_reg && !lost_reg && flags_reg[T_GTNS];
        r_switch = !r_enter && (pref_reg == 4'd0) && (!heard_reg || lost_reg)
                   && !flags_reg[T_DWELL];
        r_chan   = chan_reg;
        r_lost   = 1'b0;
        r_bars   = BARS_4;
        if (act_reg == ACT_TICK)
        begin
            r_dup   = 1'b0;
            r_rep   = 1'b0;
            r_hop   = 8'd0;
            r_light = 1'b0;
            r_lost  = lost_reg || r_enter;
            if (r_switch)
            begin
                r_chan = (chan_reg == CHAN_SCAN_A) ? CHAN_SCAN_B : CHAN_SCAN_A;
            end
            priority if (!heard_reg)
                r_bars = BARS_0;
            else if (flags_reg[T_LT500])
                r_bars = BARS_4;
            else if (flags_reg[T_LT1000])
                r_bars = BARS_3;
            else if (flags_reg[T_LT2000])
                r_bars = BARS_2;
            else if (flags_reg[T_LTNS])
                r_bars = BARS_1;
            else
                r_bars = BARS_0;
        end
        else
        begin
            r_enter  = 1'b0;
            r_switch = 1'b0;
        end
    end

    assign ram_we = fin_fire && (act_reg == ACT_FRAME) && r_unique && (seq_reg != 8'd0);

    always_comb
    begin
        state_next     = state_reg;
        tstep_next     = tstep_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        flags_next     = flags_reg;
        age_next       = age_reg;
        swd_next       = swd_reg;
        pref_next      = pref_reg;
        rep_en_next    = rep_en_reg;
        ns_next        = ns_reg;
        dwell_next     = dwell_reg;
        maxhop_next    = maxhop_reg;
        maxlen_next    = maxlen_reg;
        ltype_next     = ltype_reg;
        llen_next      = llen_reg;
        heard_next     = heard_reg;
        last_rx_next   = last_rx_reg;
        lost_next      = lost_reg;
        chan_next      = chan_reg;
        last_sw_next   = last_sw_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    hit_next   = 1'b0;
                    tstep_next = T_AGE;
                    scan_next  = '0;
                    priority if (s_axis_tuser[0] == ACT_TICK)
                        state_next = ST_TICK;
                    else if (s_axis_tdata[32] && (s_axis_tdata[48:41] != 8'd0))
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_TICK:
            begin
                flags_next[tstep_reg] = alu_res.lt;
                if (tstep_reg == T_AGE)
                begin
                    age_next = alu_res.lt ? 32'd0 : alu_res.diff;
                end
                if (tstep_reg == T_SWD)
                begin
                    swd_next = alu_res.diff;
                end
                if (tstep_reg == T_DWELL)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    tstep_next = tstep_reg + 3'd1;
                end
            end
            ST_SCAN:
            begin
                // read data is registered: it holds the entry at scan_reg - 1
                if ((scan_reg != '0) && alu_res.eq && (prev_idx < fill_reg))
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (scan_reg == CW'(DEDUP_DEPTH))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, r_bars, r_switch, r_chan, r_enter, r_lost,
                                      r_light, r_hop, r_rep, r_dup};
                    lost_next      = r_lost;
                    chan_next      = r_chan;
                    state_next     = ST_IDLE;
                    if (act_reg == ACT_FRAME)
                    begin
                        heard_next   = 1'b1;
                        last_rx_next = now_reg;
                    end
                    if (r_enter || r_switch)
                    begin
                        last_sw_next = now_reg;
                    end
                    if (ram_we)
                    begin
                        wptr_next = (wptr_reg == IW'(DEDUP_DEPTH - 1)) ? '0
                                                                      : wptr_reg + IW'(1);
                        if (fill_reg != CW'(DEDUP_DEPTH))
                        begin
                            fill_next = fill_reg + CW'(1);
                        end
                    end
                end
            end
        endcase

        if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_PREF:
                begin
                    pref_next = cfg_data[3:0];
                    priority if (cfg_data[3:0] == 4'd0)
                        chan_next = CHAN_SCAN_A;
                    else if (cfg_data[3:0] > CHAN_MAX)
                        chan_next = CHAN_MAX;
                    else
                        chan_next = cfg_data[3:0];
                end
                CFG_REPEAT_ENABLE:   rep_en_next = cfg_data[0];
                CFG_NO_SIGNAL_MS:    ns_next     = cfg_data;
                CFG_DWELL_MS:        dwell_next  = cfg_data;
                CFG_MAX_HOPS:        maxhop_next = cfg_data[7:0];
                CFG_MAX_REPEAT_LEN:  maxlen_next = cfg_data[7:0];
                CFG_LIGHT_TYPE:      ltype_next  = cfg_data[7:0];
                CFG_LIGHT_FRAME_LEN: llen_next   = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tstep_reg     <= T_AGE;
            scan_reg      <= '0;
            hit_reg       <= 1'b0;
            pref_reg      <= 4'd0;
            rep_en_reg    <= 1'b0;
            ns_reg        <= NO_SIGNAL_RST;
            dwell_reg     <= DWELL_RST;
            maxhop_reg    <= MAX_HOPS_RST;
            maxlen_reg    <= MAX_LEN_RST;
            ltype_reg     <= 8'd0;
            llen_reg      <= 8'd0;
            heard_reg     <= 1'b0;
            last_rx_reg   <= 32'd0;
            lost_reg      <= 1'b0;
            chan_reg      <= CHAN_SCAN_A;
            last_sw_reg   <= 32'd0;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tstep_reg     <= tstep_next;
            scan_reg      <= scan_next;
            hit_reg       <= hit_next;
            pref_reg      <= pref_next;
            rep_en_reg    <= rep_en_next;
            ns_reg        <= ns_next;
            dwell_reg     <= dwell_next;
            maxhop_reg    <= maxhop_next;
            maxlen_reg    <= maxlen_next;
            ltype_reg     <= ltype_next;
            llen_reg      <= llen_next;
            heard_reg     <= heard_next;
            last_rx_reg   <= last_rx_next;
            lost_reg      <= lost_next;
            chan_reg      <= chan_next;
            last_sw_reg   <= last_sw_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg    <= flags_next;
        age_reg      <= age_next;
        swd_reg      <= swd_next;
        out_data_reg <= out_data_next;
        if (in_fire)
        begin
            act_reg  <= s_axis_tuser[0];
            now_reg  <= s_axis_tdata[31:0];
            hdr_reg  <= s_axis_tdata[32];
            src_reg  <= s_axis_tdata[40:33];
            seq_reg  <= s_axis_tdata[48:41];
            hop_reg  <= s_axis_tdata[56:49];
            mt_reg   <= s_axis_tdata[64:57];
            flen_reg <= s_axis_tdata[72:65];
            pay_reg  <= s_axis_tdata[73];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEDUP_DEPTH))
        else $error("ring fill count beyond depth");

    a_dup_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (!m_axis_tdata[1] && !m_axis_tdata[10]))
        else $error("duplicate item also repeated or delivered");

    a_enter_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tdata[11] && !m_axis_tdata[17]))
        else $error("no-signal entry without lost status or with a switch");

    a_hop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[9:2] == 8'd0))
        else $error("repeat hop set without rebroadcast");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer idle straight after accepting an item");

endmodule
